@@ src/smb_pkg.sv @@
// Shared types and constants for the slot mailbox.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package smb_pkg;

	localparam int SLOT_COUNT_DEF    = 8;
	localparam int MESSAGE_BYTES_DEF = 8;

	localparam logic OP_SEND = 1'b0;
	localparam logic OP_RECV = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic advance;
		logic finish;
	} smb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic last;
	} smb_stat_t;

endpackage

`default_nettype wire

@@ src/smb_ctrl.sv @@
// Scan controller for the slot mailbox.
// Depends on smb_pkg for the state, command and status types.
`default_nettype none

module smb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire smb_pkg::smb_stat_t stat,
	output smb_pkg::smb_cmd_t      cmd,
	output logic                   busy
);
	import smb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.hit || stat.last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_SCAN: begin
				busy        = 1'b1;
				cmd.finish  = stat.hit || stat.last;
				cmd.advance = !(stat.hit || stat.last);
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/smb_datapath.sv @@
// Slot storage, scan index and result registers for the slot mailbox.
// Depends on smb_pkg for op and status codes and the command/status structs.
`default_nettype none

module smb_datapath #(
	parameter int SLOT_COUNT    = smb_pkg::SLOT_COUNT_DEF,
	parameter int MESSAGE_BYTES = smb_pkg::MESSAGE_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire smb_pkg::smb_cmd_t  cmd,
	output smb_pkg::smb_stat_t      stat,
	input  wire logic               operation,
	input  wire logic signed [15:0] sender_id,
	input  wire logic [14:0]        receiver_id,
	input  wire logic [63:0]        payload_in,
	output logic                    done,
	output logic [1:0]              status,
	output logic [63:0]             payload_out
);
	import smb_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PAY_W = 8 * MESSAGE_BYTES;

	// request captured at accept
	logic             op_q;
	logic             snd_free_q;
	logic [14:0]      rcv_q;
	logic [PAY_W-1:0] pay_q;

	// per-slot flags: sender free, receiver present
	logic [SLOT_COUNT-1:0] free_q;
	logic [SLOT_COUNT-1:0] rvalid_q;

	logic [14:0]      rcv_mem_q [SLOT_COUNT];
	logic [PAY_W-1:0] pay_mem_q [SLOT_COUNT];
	logic [14:0]      rcv_rd_q;
	logic [PAY_W-1:0] pay_rd_q;

	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	logic             hit;
	logic             commit;

	logic             done_q;
	logic [1:0]       status_q;
	logic [63:0]      payload_out_q;

	assign rd_addr = cmd.load ? '0 : IDX_W'(idx_q + 1'b1);
	assign rd_en   = cmd.load || cmd.advance;

	assign hit = (op_q == OP_SEND) ? free_q[idx_q]
	                               : (rvalid_q[idx_q] && (rcv_rd_q == rcv_q));
	assign stat.hit  = hit;
	assign stat.last = (idx_q == IDX_W'(SLOT_COUNT - 1));
	assign commit    = cmd.finish && hit;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= operation;
			snd_free_q <= (sender_id == 16'sd0) || sender_id[15];
			rcv_q      <= receiver_id;
			pay_q      <= payload_in[PAY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rcv_rd_q <= rcv_mem_q[rd_addr];
			pay_rd_q <= pay_mem_q[rd_addr];
		end
		if (commit && (op_q == OP_SEND)) begin
			rcv_mem_q[idx_q] <= rcv_q;
			pay_mem_q[idx_q] <= pay_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.advance) begin
			idx_q <= IDX_W'(idx_q + 1'b1);
		end
	end

	// a slot written with a zero or negative sender stays free yet receivable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q   <= '1;
			rvalid_q <= '0;
		end else if (commit) begin
			if (op_q == OP_SEND) begin
				free_q[idx_q]   <= snd_free_q;
				rvalid_q[idx_q] <= 1'b1;
			end else begin
				free_q[idx_q]   <= 1'b1;
				rvalid_q[idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (hit) begin
				status_q <= ST_DONE;
			end else if (op_q == OP_SEND) begin
				status_q <= ST_FULL;
			end else begin
				status_q <= ST_EMPTY;
			end
			payload_out_q <= (hit && (op_q == OP_RECV)) ? 64'(pay_rd_q) : 64'd0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign payload_out = payload_out_q;

endmodule

`default_nettype wire

@@ src/slot_mailbox_send_receive_top.sv @@
// Top level of the slot mailbox: controller plus datapath.
// Depends on smb_pkg, smb_ctrl and smb_datapath.
`default_nettype none

// Usage
//   Request channel: drive operation, sender_id, receiver_id and payload_in
//   and raise start; the item is taken at the edge where start is high and
//   busy is low. busy stays high while the slot table is scanned.
//   Result channel: done is high for one cycle with status and payload_out.
//   The receiver cannot stall; it must take the result in that cycle.
//   A send takes the lowest slot whose sender is zero or negative; a receive
//   takes the lowest slot whose receiver matches and frees it.
//   A scan stops at the first matching slot or at the last slot, and done
//   is registered from that final scan step. The scan reads one slot per
//   cycle through the single read port of the slot memories; busy falls as
//   done rises, so the next item can be accepted at the edge that ends the
//   done cycle; a new item is not taken while a scan is running.
//   Reset: all slots are empty and free; per-slot flags reset at once, so no
//   clearing pass is needed and the block accepts an item right after reset.

module slot_mailbox_send_receive_top #(
	parameter int SLOT_COUNT    = smb_pkg::SLOT_COUNT_DEF,
	parameter int MESSAGE_BYTES = smb_pkg::MESSAGE_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               operation,
	input  wire logic signed [15:0] sender_id,
	input  wire logic [14:0]        receiver_id,
	input  wire logic [63:0]        payload_in,
	output logic                    done,
	output logic [1:0]              status,
	output logic [63:0]             payload_out
);
	import smb_pkg::*;

	smb_cmd_t  cmd;
	smb_stat_t stat;

	smb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	smb_datapath #(
		.SLOT_COUNT    (SLOT_COUNT),
		.MESSAGE_BYTES (MESSAGE_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.operation   (operation),
		.sender_id   (sender_id),
		.receiver_id (receiver_id),
		.payload_in  (payload_in),
		.done        (done),
		.status      (status),
		.payload_out (payload_out)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start a scan");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while scan still running");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_DONE)) |-> (payload_out == 64'd0))
		else $error("failed request returned a payload");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_DONE || status == ST_FULL || status == ST_EMPTY))
		else $error("undefined status code");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for slot_mailbox_send_receive_top: directed and random
// send/receive items against a behavioral model of the slot table.
// Depends on smb_pkg and the mailbox RTL under src.

module tb;
	import smb_pkg::*;

	localparam int NSLOT  = SLOT_COUNT_DEF;
	localparam int NBYTES = MESSAGE_BYTES_DEF;
	localparam logic [63:0] KEEP_MASK = {64{1'b1}} >> (64 - 8 * NBYTES);

	typedef struct {
		logic [1:0]  status;
		logic [63:0] payload;
	} mbox_reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               operation = OP_SEND;
	logic signed [15:0] sender_id = '0;
	logic [14:0]        receiver_id = '0;
	logic [63:0]        payload_in = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [63:0]        payload_out;

	// model copy of the slot table
	logic [15:0] mdl_sender [NSLOT];
	logic [15:0] mdl_receiver [NSLOT];
	logic [63:0] mdl_payload [NSLOT];

	mbox_reply_t pending_replies[$];

	int mismatch_count = 0;
	int replies_checked = 0;
	int sends_seen = 0;
	int sends_full = 0;
	int recvs_seen = 0;
	int recvs_empty = 0;

	slot_mailbox_send_receive_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.sender_id   (sender_id),
		.receiver_id (receiver_id),
		.payload_in  (payload_in),
		.done        (done),
		.status      (status),
		.payload_out (payload_out)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic clear_slot_table();
		for (int k = 0; k < NSLOT; k++) begin
			mdl_sender[k]   = 16'hFFFF;
			mdl_receiver[k] = 16'hFFFF;
			mdl_payload[k]  = '0;
		end
	endtask

	// Apply one accepted item to the model table and return the reply it causes.
	function automatic mbox_reply_t predict_mailbox_reply(input logic op,
			input logic [15:0] snd, input logic [14:0] rcv, input logic [63:0] pay);
		mbox_reply_t r;
		logic        found;
		found = 1'b0;
		r.payload = '0;
		if (op == OP_SEND) begin
			r.status = ST_FULL;
			sends_seen++;
			for (int k = 0; k < NSLOT; k++) begin
				// a zero or negative sender leaves the slot open for overwrite
				if (!found && (mdl_sender[k] == 16'd0 || mdl_sender[k][15])) begin
					mdl_sender[k]   = snd;
					mdl_receiver[k] = {1'b0, rcv};
					mdl_payload[k]  = pay & KEEP_MASK;
					r.status = ST_DONE;
					found = 1'b1;
				end
			end
			if (!found)
				sends_full++;
		end else begin
			r.status = ST_EMPTY;
			recvs_seen++;
			for (int k = 0; k < NSLOT; k++) begin
				if (!found && mdl_receiver[k] == {1'b0, rcv}) begin
					r.payload = mdl_payload[k];
					mdl_sender[k]   = 16'hFFFF;
					mdl_receiver[k] = 16'hFFFF;
					r.status = ST_DONE;
					found = 1'b1;
				end
			end
			if (!found)
				recvs_empty++;
		end
		return r;
	endfunction

	int sender_gap_pct = 0;

	// Drive one item and hold it until the block takes it. Start stays high
	// between back-to-back items and only drops when a gap is inserted.
	task automatic send_item(input logic op, input logic [15:0] snd,
			input logic [14:0] rcv, input logic [63:0] pay);
		if (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_gap_pct);
		end
		start       <= 1'b1;
		operation   <= op;
		sender_id   <= snd;
		receiver_id <= rcv;
		payload_in  <= pay;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_replies.push_back(predict_mailbox_reply(op, snd, rcv, pay));
	endtask

	// reply checker: done marks one result per accepted item
	always @(posedge clk) begin
		mbox_reply_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected reply, status", {62'd0, status}, 64'd0);
			end else begin
				want = pending_replies.pop_front();
				replies_checked++;
				if (status !== want.status)
					report_mismatch("status", {62'd0, status}, {62'd0, want.status});
				if (payload_out !== want.payload)
					report_mismatch("payload_out", payload_out, want.payload);
			end
		end
	end

	task automatic test_empty_table();
		send_item(OP_RECV, 16'd1, 15'd1, 64'd0);
		send_item(OP_RECV, 16'h7FFF, 15'h7FFF, {64{1'b1}});
		// freed slots hold all ones, so even id zero finds nothing
		send_item(OP_RECV, 16'h8000, 15'd0, 64'hA5A5_5A5A_F00F_0FF0);
	endtask

	task automatic test_fill_until_full();
		send_item(OP_SEND, 16'd1,     15'd5,     64'd0);
		send_item(OP_SEND, 16'h7FFF,  15'd0,     {64{1'b1}});
		send_item(OP_SEND, 16'd2,     15'h7FFF,  64'h0123_4567_89AB_CDEF);
		send_item(OP_SEND, 16'd3,     15'd5,     64'hFEDC_BA98_7654_3210);
		send_item(OP_SEND, 16'd4,     15'd7,     64'h8000_0000_0000_0001);
		send_item(OP_SEND, 16'd5,     15'd8,     64'h5555_5555_5555_5555);
		send_item(OP_SEND, 16'd6,     15'd9,     64'hAAAA_AAAA_AAAA_AAAA);
		send_item(OP_SEND, 16'h5A5A,  15'h2AAA,  64'h0000_0001_0000_0000);
		send_item(OP_SEND, 16'd100,   15'h5555,  64'hDEAD_BEEF_CAFE_F00D);
		// duplicate ids come out lowest slot first
		send_item(OP_RECV, 16'd0,     15'd5,     64'd0);
		send_item(OP_RECV, 16'd0,     15'd5,     64'd0);
		send_item(OP_RECV, 16'd0,     15'd5,     64'd0);
		send_item(OP_RECV, 16'hFFFF,  15'd0,     {64{1'b1}});
	endtask

	task automatic test_nonpositive_sender();
		send_item(OP_SEND, 16'd0,     15'd11,    64'h1111_2222_3333_4444);
		// slot still counts as free, so this one overwrites it
		send_item(OP_SEND, 16'h8000,  15'd12,    64'h9999_8888_7777_6666);
		send_item(OP_RECV, 16'd0,     15'd11,    64'd0);
		send_item(OP_RECV, 16'd0,     15'd12,    64'd0);
		send_item(OP_SEND, 16'hFFFF,  15'd13,    64'h0F0F_0F0F_0F0F_0F0F);
		send_item(OP_RECV, 16'd0,     15'd13,    64'd0);
	endtask

	// Mostly ids from a small pool so receives find messages; the rest spread
	// over the whole field range.
	task automatic test_random_traffic(input int count, input int gap_pct);
		logic        op;
		logic [15:0] snd;
		logic [14:0] rcv;
		logic [63:0] pay;
		int          roll;
		sender_gap_pct = gap_pct;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(99) < 50) ? OP_SEND : OP_RECV;
			if ($urandom_range(9) < 8)
				rcv = 15'($urandom_range(1, 6));
			else
				rcv = 15'($urandom);
			roll = $urandom_range(19);
			case (roll)
				0: snd = 16'd0;
				1: snd = {1'b1, 15'($urandom)};
				2: snd = 16'($urandom);
				default: snd = 16'($urandom_range(1, 32767));
			endcase
			pay = {$urandom, $urandom};
			send_item(op, snd, rcv, pay);
		end
		sender_gap_pct = 0;
	endtask

	initial begin
		clear_slot_table();
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_fill_until_full();
		test_nonpositive_sender();
		test_random_traffic(130, 0);
		test_random_traffic(130, 45);
		test_random_traffic(130, 18);
		test_random_traffic(110, 0);
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (NSLOT + 4)
			@(posedge clk);
		$display("Ran %0d sends (%0d table full) and %0d receives (%0d no message),",
			sends_seen, sends_full, recvs_seen, recvs_empty);
		$display("with sender gaps of 0, 18 and 45 percent; %0d replies compared.",
			replies_checked);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Timeout waiting for the mailbox");
		$display("Mismatches found");
		$finish;
	end

endmodule
